/* rtl/emps_pkg.sv */
package emps_pkg;

    // parameter defaults
    localparam int COUNT_BITS_DEF      = 16;
    localparam int SCALE_FRAC_BITS_DEF = 16;

    // fixed field widths
    localparam int READING_W   = 32;
    localparam int SCALE_W     = 32;
    localparam int INTERVAL_W  = 16;
    localparam int MODE_TICK_W = 16;
    localparam int ENABLE_W    = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int KIND_W      = 2;

    // a mixed count is scaled to a per-second rate against interval_ms
    localparam int MS_PER_SEC = 1000;

    // ticks swallowed after reset
    localparam logic [1:0] WARMUP_TICKS = 2'd2;

    // report_enable bit positions
    localparam int EN_POWER   = 0;
    localparam int EN_CURRENT = 1;
    localparam int EN_VOLTAGE = 2;

    // register reset values
    localparam logic [INTERVAL_W-1:0]  INTERVAL_RST      = 16'd60000;
    localparam logic [MODE_TICK_W-1:0] CHANGE_EVERY_RST  = 16'd8;
    localparam logic [SCALE_W-1:0]     SCALE_RST         = 32'd65536;
    localparam logic [ENABLE_W-1:0]    REPORT_ENABLE_RST = 3'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTERVAL_MS   = 3'd0,
        CFG_CHANGE_EVERY  = 3'd1,
        CFG_POWER_SCALE   = 3'd2,
        CFG_CURRENT_SCALE = 3'd3,
        CFG_VOLTAGE_SCALE = 3'd4,
        CFG_REPORT_ENABLE = 3'd5
    } cfg_idx_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_POWER   = 2'd0,
        KIND_CURRENT = 2'd1,
        KIND_VOLTAGE = 2'd2
    } kind_t;

    typedef struct packed {
        logic [INTERVAL_W-1:0]  interval_ms;
        logic [MODE_TICK_W-1:0] change_every;
        logic [SCALE_W-1:0]     power_scale;
        logic [SCALE_W-1:0]     current_scale;
        logic [SCALE_W-1:0]     voltage_scale;
        logic [ENABLE_W-1:0]    report_enable;
    } cfg_t;

    // what one tick has to report, passed from the front stage to the buffer
    typedef struct packed {
        logic has_mixed;
        logic mixed_current;
        logic has_power;
        logic select_level;
    } item_ctrl_t;

endpackage

/* rtl/emps_cfg.sv */
module emps_cfg
    import emps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_INTERVAL_MS:   cfg_next.interval_ms   = cfg_data[INTERVAL_W-1:0];
                CFG_CHANGE_EVERY:  cfg_next.change_every  = cfg_data[MODE_TICK_W-1:0];
                CFG_POWER_SCALE:   cfg_next.power_scale   = cfg_data[SCALE_W-1:0];
                CFG_CURRENT_SCALE: cfg_next.current_scale = cfg_data[SCALE_W-1:0];
                CFG_VOLTAGE_SCALE: cfg_next.voltage_scale = cfg_data[SCALE_W-1:0];
                CFG_REPORT_ENABLE: cfg_next.report_enable = cfg_data[ENABLE_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interval_ms   <= INTERVAL_RST;
            cfg_reg.change_every  <= CHANGE_EVERY_RST;
            cfg_reg.power_scale   <= SCALE_RST;
            cfg_reg.current_scale <= SCALE_RST;
            cfg_reg.voltage_scale <= SCALE_RST;
            cfg_reg.report_enable <= REPORT_ENABLE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/emps_front.sv */
module emps_front
    import emps_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COUNT_BITS-1:0] power_pulses,
    input  logic [COUNT_BITS-1:0] mixed_pulses,
    input  logic                  take,
    output logic                  item_valid,
    output item_ctrl_t            item_ctrl,
    output logic [COUNT_BITS-1:0] item_power,
    output logic [COUNT_BITS-1:0] item_mixed
);

    localparam int RATE_W = COUNT_BITS + 10;

    logic [1:0]             warmup_reg, warmup_next;
    logic                   mode_reg, mode_next;
    logic [MODE_TICK_W-1:0] ticks_reg, ticks_next;
    logic                   valid_reg, valid_next;
    item_ctrl_t             ctrl_reg, ctrl_next;
    logic [COUNT_BITS-1:0]  power_reg, power_next;
    logic [COUNT_BITS-1:0]  mixed_reg, mixed_next;

    logic              accept;
    logic              warming;
    logic [RATE_W-1:0] mixed_rate;
    logic              mixed_slow;
    logic              power_small;
    logic              mixed_en;

    assign in_stall = valid_reg && !take;
    assign accept   = in_valid && !in_stall;
    assign warming  = warmup_reg != WARMUP_TICKS;

    // 1 Hz or slower on the second channel reads as zero
    assign mixed_rate  = RATE_W'(mixed_pulses) * RATE_W'(MS_PER_SEC);
    assign mixed_slow  = mixed_rate <= RATE_W'(cfg.interval_ms);
    assign power_small = power_pulses[COUNT_BITS-1:1] == '0;
    assign mixed_en    = mode_reg ? cfg.report_enable[EN_CURRENT]
                                  : cfg.report_enable[EN_VOLTAGE];

    always_comb
    begin
        warmup_next = warmup_reg;
        mode_next   = mode_reg;
        ticks_next  = ticks_reg;
        valid_next  = take ? 1'b0 : valid_reg;
        ctrl_next   = ctrl_reg;
        power_next  = power_reg;
        mixed_next  = mixed_reg;

        if (accept)
        begin
            if (warming)
            begin
                warmup_next = warmup_reg + 2'd1;
            end
            else
            begin
                if (ticks_reg == cfg.change_every)
                begin
                    mode_next  = !mode_reg;
                    ticks_next = '0;
                end
                else
                begin
                    ticks_next = ticks_reg + MODE_TICK_W'(1);
                end
                ctrl_next.has_mixed     = (ticks_reg != '0) && mixed_en;
                ctrl_next.mixed_current = mode_reg;
                ctrl_next.has_power     = cfg.report_enable[EN_POWER];
                ctrl_next.select_level  = mode_next;
                valid_next  = ctrl_next.has_mixed || ctrl_next.has_power;
                power_next  = power_small ? '0 : power_pulses;
                mixed_next  = mixed_slow ? '0 : mixed_pulses;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warmup_reg <= '0;
            mode_reg   <= 1'b0;
            ticks_reg  <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            warmup_reg <= warmup_next;
            mode_reg   <= mode_next;
            ticks_reg  <= ticks_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctrl_reg  <= ctrl_next;
        power_reg <= power_next;
        mixed_reg <= mixed_next;
    end

    assign item_valid = valid_reg;
    assign item_ctrl  = ctrl_reg;
    assign item_power = power_reg;
    assign item_mixed = mixed_reg;

endmodule

/* rtl/emps_scale.sv */
module emps_scale
    import emps_pkg::*;
#(
    parameter int COUNT_BITS      = COUNT_BITS_DEF,
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
)
(
    input  logic [COUNT_BITS-1:0] count,
    input  logic [SCALE_W-1:0]    scale,
    output logic [READING_W-1:0]  reading
);

    localparam int PROD_W = COUNT_BITS + SCALE_W;

    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] shifted;

    assign prod    = PROD_W'(count) * PROD_W'(scale);
    assign shifted = prod >> SCALE_FRAC_BITS;

    // saturate at the reading width
    assign reading = (shifted[PROD_W-1:READING_W] != '0) ? '1
                                                         : shifted[READING_W-1:0];

endmodule

/* rtl/emps_outbuf.sv */
module emps_outbuf
    import emps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  item_ctrl_t           item_ctrl,
    input  logic [READING_W-1:0] mixed_reading,
    input  logic [READING_W-1:0] power_reading,
    output logic                 take,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [KIND_W-1:0]    kind,
    output logic [READING_W-1:0] reading,
    output logic                 select_level,
    output logic                 last
);

    logic [1:0]           cnt_reg, cnt_next;
    logic                 head_reg, head_next;
    kind_t                kind_reg [2];
    logic [READING_W-1:0] reading_reg [2];
    logic                 last_reg [2];
    logic                 sel_reg;

    logic  pop;
    logic  load;
    kind_t mixed_kind;

    assign out_valid = cnt_reg != 2'd0;
    assign pop       = out_valid && !out_stall;
    assign take      = item_valid && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop));
    assign load      = take;
    assign mixed_kind = item_ctrl.mixed_current ? KIND_CURRENT : KIND_VOLTAGE;

    always_comb
    begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        if (load)
        begin
            cnt_next  = 2'(item_ctrl.has_mixed) + 2'(item_ctrl.has_power);
            head_next = 1'b0;
        end
        else if (pop)
        begin
            cnt_next  = cnt_reg - 2'd1;
            head_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            head_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            head_reg <= head_next;
        end
    end

    // mixed reading goes first, power closes the tick
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sel_reg        <= item_ctrl.select_level;
            kind_reg[1]    <= KIND_POWER;
            reading_reg[1] <= power_reading;
            last_reg[1]    <= 1'b1;
            if (item_ctrl.has_mixed)
            begin
                kind_reg[0]    <= mixed_kind;
                reading_reg[0] <= mixed_reading;
                last_reg[0]    <= !item_ctrl.has_power;
            end
            else
            begin
                kind_reg[0]    <= KIND_POWER;
                reading_reg[0] <= power_reading;
                last_reg[0]    <= 1'b1;
            end
        end
    end

    assign kind         = kind_reg[head_reg];
    assign reading      = reading_reg[head_reg];
    assign last         = last_reg[head_reg];
    assign select_level = sel_reg;

endmodule

/* rtl/energy_meter_pulse_scaler_core.sv */
// energy meter pulse scaler
//
// input channel (in_valid / in_stall) carries one update tick per request:
// the pulse counts of the power output and of the shared current/voltage
// output. output channel (out_valid / out_stall) carries one reading per
// request: kind, reading, select_level and last, with last set on the final
// reading of a tick. a tick gives zero, one or two readings; the first two
// ticks after reset give none.
// a taken tick is registered in the front stage, then in the result buffer.
// throughput: one tick per cycle while out_stall is low and ticks give at
// most one reading; a two-reading tick fills the two-entry result buffer and
// the next tick waits until its second reading leaves. the user writes config
// via cfg_wr_en / cfg_index / cfg_data only while idle; nothing enforces it.
// reset: config registers go to their defaults, warmup and mode counters
// clear (voltage mode), both pipeline stages empty.
// out_stall holds the current reading; the front register still takes one
// more tick, after which in_stall follows out_stall.
module energy_meter_pulse_scaler_core
    import emps_pkg::*;
#(
    parameter int COUNT_BITS      = COUNT_BITS_DEF,
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // tick requests
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COUNT_BITS-1:0] power_pulses,
    input  logic [COUNT_BITS-1:0] mixed_pulses,
    // reading requests
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [KIND_W-1:0]     kind,
    output logic [READING_W-1:0]  reading,
    output logic                  select_level,
    output logic                  last
);

    cfg_t                  cfg;
    logic                  take;
    logic                  item_valid;
    item_ctrl_t            item_ctrl;
    logic [COUNT_BITS-1:0] item_power;
    logic [COUNT_BITS-1:0] item_mixed;
    logic [SCALE_W-1:0]    mixed_scale;
    logic [READING_W-1:0]  mixed_reading;
    logic [READING_W-1:0]  power_reading;

    // register file
    emps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register: warmup, mode sequencing, small-count and slow-rate gating
    emps_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .power_pulses (power_pulses),
        .mixed_pulses (mixed_pulses),
        .take         (take),
        .item_valid   (item_valid),
        .item_ctrl    (item_ctrl),
        .item_power   (item_power),
        .item_mixed   (item_mixed)
    );

    // the mixed channel uses the scale of the mode that was active on this tick
    assign mixed_scale = item_ctrl.mixed_current ? cfg.current_scale : cfg.voltage_scale;

    // one multiplier per reading, both feed the result buffer registers
    emps_scale #(
        .COUNT_BITS      (COUNT_BITS),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_scale_mixed (
        .count   (item_mixed),
        .scale   (mixed_scale),
        .reading (mixed_reading)
    );

    emps_scale #(
        .COUNT_BITS      (COUNT_BITS),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_scale_power (
        .count   (item_power),
        .scale   (cfg.power_scale),
        .reading (power_reading)
    );

    // two-entry result buffer, drained one reading per request
    emps_outbuf u_outbuf (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ctrl     (item_ctrl),
        .mixed_reading (mixed_reading),
        .power_reading (power_reading),
        .take          (take),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .reading       (reading),
        .select_level  (select_level),
        .last          (last)
    );

endmodule

/* rtl/emps_checker.sv */
module emps_checker
    import emps_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [KIND_W-1:0]    kind,
    input logic [READING_W-1:0] reading,
    input logic                 select_level,
    input logic                 last
);

    // a stalled reading holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(reading) && $stable(kind)
            && $stable(last) && $stable(select_level))
        else $error("stalled reading changed");

    // power always closes its tick
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_POWER) |-> last)
        else $error("power reading not marked last");

    // the rest of a tick follows at once
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("second reading of a tick missing");

    // both readings of a tick carry the same select level
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> select_level == $past(select_level))
        else $error("select level changed within a tick");

endmodule

bind energy_meter_pulse_scaler_core emps_checker u_emps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .reading      (reading),
    .select_level (select_level),
    .last         (last)
);

/* dv/tb_energy_meter_pulse_scaler_core.sv */
module tb_energy_meter_pulse_scaler_core;
    import emps_pkg::*;

    // block widths at their defaults
    localparam int CNT_W  = COUNT_BITS_DEF;
    localparam int FRAC_W = SCALE_FRAC_BITS_DEF;

    // cycles left after the last reading, for ticks that leave nothing behind
    localparam int SETTLE_CYCLES = 8;

    // indexes the register file does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [CNT_W-1:0]      power_pulses;
    logic [CNT_W-1:0]      mixed_pulses;
    logic                  out_valid;
    logic                  out_stall;
    logic [KIND_W-1:0]     kind;
    logic [READING_W-1:0]  reading;
    logic                  select_level;
    logic                  last;

    energy_meter_pulse_scaler_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .power_pulses (power_pulses),
        .mixed_pulses (mixed_pulses),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .reading      (reading),
        .select_level (select_level),
        .last         (last)
    );

    // one reading as the block should present it
    typedef struct packed {
        kind_t                kind;
        logic [READING_W-1:0] value;
        logic                 sel;
        logic                 last;
    } meter_reading_t;

    // readings predicted but not yet seen, oldest first
    meter_reading_t readings_due[$];

    // shadow of the register file and of the tick state
    cfg_t                   regs;
    logic [1:0]             warmup;
    logic                   in_current_mode;
    logic [MODE_TICK_W-1:0] mode_ticks;

    int mismatches;
    bit idling_on;
    int stall_left;

    // 2 time unit clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // count times Q16.16 scale, fraction dropped, clamped to 32 bits
    function automatic logic [READING_W-1:0] scale_count(
        input logic [31:0]      cnt,
        input logic [SCALE_W-1:0] sc
    );
        logic [63:0] prod;
        logic [63:0] shifted;
        prod    = {32'b0, cnt} * {32'b0, sc};
        shifted = prod >> FRAC_W;
        if (shifted > 64'hFFFF_FFFF)
            shifted = 64'hFFFF_FFFF;
        return shifted[READING_W-1:0];
    endfunction

    // advance the shadow state by one accepted tick and queue its readings
    task automatic predict_tick_readings(
        input logic [CNT_W-1:0] pp,
        input logic [CNT_W-1:0] mc
    );
        meter_reading_t rd [2];
        int             n;
        logic [31:0]    pcnt;
        logic [31:0]    mcnt;
        n = 0;
        // first ticks after reset only prime the meter
        if (warmup < WARMUP_TICKS)
        begin
            warmup = warmup + 2'd1;
            return;
        end
        // power count of 0 or 1 is noise
        pcnt = (pp <= 1) ? 32'd0 : {16'b0, pp};
        // second channel at 1 Hz or slower reads zero
        if ({48'b0, mc} * MS_PER_SEC <= {48'b0, regs.interval_ms})
            mcnt = 32'd0;
        else
            mcnt = {16'b0, mc};
        // no mixed reading on the tick where the mode counter sits at zero
        if (mode_ticks != 0)
        begin
            if (in_current_mode)
            begin
                if (regs.report_enable[EN_CURRENT])
                begin
                    rd[n].kind  = KIND_CURRENT;
                    rd[n].value = scale_count(mcnt, regs.current_scale);
                    n++;
                end
            end
            else if (regs.report_enable[EN_VOLTAGE])
            begin
                rd[n].kind  = KIND_VOLTAGE;
                rd[n].value = scale_count(mcnt, regs.voltage_scale);
                n++;
            end
        end
        if (regs.report_enable[EN_POWER])
        begin
            rd[n].kind  = KIND_POWER;
            rd[n].value = scale_count(pcnt, regs.power_scale);
            n++;
        end
        // mode flip, counter keeps running past a lowered threshold
        if (mode_ticks == regs.change_every)
        begin
            in_current_mode = ~in_current_mode;
            mode_ticks      = '0;
        end
        else
            mode_ticks = mode_ticks + 1'b1;
        for (int k = 0; k < n; k++)
        begin
            rd[k].sel  = in_current_mode;
            rd[k].last = (k == n - 1);
            readings_due.push_back(rd[k]);
        end
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_reading;
        meter_reading_t want;
        if (readings_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected reading kind=%0d value=%0h",
                                      kind, reading));
            return;
        end
        want = readings_due.pop_front();
        if (kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
        if (reading !== want.value)
            report_mismatch($sformatf("reading %0h, want %0h", reading, want.value));
        if (select_level !== want.sel)
            report_mismatch($sformatf("select_level %0b, want %0b",
                                      select_level, want.sel));
        if (last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", last, want.last));
    endtask

    // reading side: sample the handshake, then pick the next stall level
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_reading();
        if (stall_left > 0)
        begin
            stall_left--;
            if (stall_left == 0)
                out_stall <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 7) == 0)
        begin
            // start a stall burst of random length
            stall_left = $urandom_range(1, 14);
            out_stall <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one register write, enable dropped on the following cycle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_INTERVAL_MS:   regs.interval_ms   = data[INTERVAL_W-1:0];
            CFG_CHANGE_EVERY:  regs.change_every  = data[MODE_TICK_W-1:0];
            CFG_POWER_SCALE:   regs.power_scale   = data[SCALE_W-1:0];
            CFG_CURRENT_SCALE: regs.current_scale = data[SCALE_W-1:0];
            CFG_VOLTAGE_SCALE: regs.voltage_scale = data[SCALE_W-1:0];
            CFG_REPORT_ENABLE: regs.report_enable = data[ENABLE_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // one tick request, held until taken
    task automatic send_tick(input logic [CNT_W-1:0] pp,
                             input logic [CNT_W-1:0] mc);
        // sender gap of random length
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        power_pulses <= pp;
        mixed_pulses <= mc;
        do
            @(posedge clk);
        while (in_stall);
        predict_tick_readings(pp, mc);
    endtask

    // random counts biased toward the thresholds
    task automatic send_random_tick;
        logic [CNT_W-1:0] pp;
        logic [CNT_W-1:0] mc;
        logic [CNT_W-1:0] thr;
        thr = CNT_W'(regs.interval_ms / MS_PER_SEC);
        case ($urandom_range(0, 9))
            0:       pp = CNT_W'($urandom_range(0, 2));
            1:       pp = '1;
            default: pp = CNT_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       mc = thr;
            1:       mc = thr + 1'b1;
            2:       mc = '0;
            3:       mc = '1;
            default: mc = CNT_W'($urandom);
        endcase
        send_tick(pp, mc);
    endtask

    // quiet the sender and let every pending reading come out
    task automatic wait_readings_drained;
        in_valid <= 1'b0;
        while (readings_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SCALE_W-1:0] random_scale;
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return SCALE_RST;
            default: return $urandom;
        endcase
    endfunction

    // fresh register set, extremes mixed in
    task automatic randomize_registers;
        logic [INTERVAL_W-1:0]  ivl;
        logic [MODE_TICK_W-1:0] chg;
        case ($urandom_range(0, 4))
            0:       ivl = 16'd1;
            1:       ivl = '1;
            2:       ivl = 16'd1000;
            default: ivl = INTERVAL_W'($urandom_range(1, 65535));
        endcase
        case ($urandom_range(0, 5))
            0:       chg = '0;
            1:       chg = 16'd1;
            2:       chg = '1;
            default: chg = MODE_TICK_W'($urandom_range(2, 20));
        endcase
        wait_readings_drained();
        write_reg(CFG_INTERVAL_MS, {16'b0, ivl});
        write_reg(CFG_CHANGE_EVERY, {16'b0, chg});
        write_reg(CFG_POWER_SCALE, random_scale());
        write_reg(CFG_CURRENT_SCALE, random_scale());
        write_reg(CFG_VOLTAGE_SCALE, random_scale());
        // mostly everything on, sometimes a partial mask
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_REPORT_ENABLE, $urandom_range(0, 7));
        else
            write_reg(CFG_REPORT_ENABLE, {29'b0, REPORT_ENABLE_RST});
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_SPARE_HI, $urandom);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset values: warmup ticks, small counts, 1 Hz edge at 60 s, first flip
    task automatic test_warmup_and_defaults;
        send_tick(16'hFFFF, 16'hFFFF);
        send_tick(16'h1234, 16'h5678);
        send_tick(16'd0, 16'd0);
        send_tick(16'd1, 16'd60);
        send_tick(16'd2, 16'd61);
        send_tick(16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 6; i++)
            send_random_tick();
    endtask

    // every register at its extremes, spare indexes ignored
    task automatic test_register_extremes;
        logic [ENABLE_W-1:0] masks [4];
        masks = '{3'd0, 3'd2, 3'd4, 3'd6};
        wait_readings_drained();
        write_reg(CFG_SPARE_LO, '0);
        write_reg(CFG_SPARE_HI, '1);
        write_reg(CFG_INTERVAL_MS, 32'd65535);
        send_tick(16'd2, 16'd65);
        send_tick(16'd3, 16'd66);
        wait_readings_drained();
        // threshold at zero, under the running mode counter, which keeps counting
        write_reg(CFG_CHANGE_EVERY, '0);
        write_reg(CFG_POWER_SCALE, '1);
        send_tick(16'hFFFF, 16'hFFFF);
        send_tick(16'h8000, 16'h0001);
        wait_readings_drained();
        write_reg(CFG_CHANGE_EVERY, 32'd1);
        write_reg(CFG_CURRENT_SCALE, '1);
        write_reg(CFG_VOLTAGE_SCALE, '0);
        for (int i = 0; i < 4; i++)
            send_tick(16'hFFFF, 16'hFFFF);
        wait_readings_drained();
        // zero interval, only a zero mixed count reads zero
        write_reg(CFG_INTERVAL_MS, '0);
        write_reg(CFG_VOLTAGE_SCALE, '1);
        send_tick(16'd5, 16'd0);
        send_tick(16'd5, 16'd1);
        send_tick(16'd5, 16'd1);
        // partial masks, a tick may give nothing
        foreach (masks[m])
        begin
            wait_readings_drained();
            write_reg(CFG_REPORT_ENABLE, {29'b0, masks[m]});
            send_tick(16'hFFFF, 16'd1);
            send_tick(16'hFFFF, 16'd1);
        end
        wait_readings_drained();
        write_reg(CFG_POWER_SCALE, '0);
        write_reg(CFG_REPORT_ENABLE, 32'd7);
        send_tick(16'hFFFF, 16'hFFFF);
    endtask

    // lower the threshold under the counter, then raise it just ahead again
    task automatic test_mode_counter_past;
        wait_readings_drained();
        write_reg(CFG_INTERVAL_MS, 32'd1000);
        write_reg(CFG_CHANGE_EVERY, 32'd1000);
        write_reg(CFG_POWER_SCALE, {16'b0, SCALE_RST[15:0]} | SCALE_RST);
        while (mode_ticks < 5)
            send_random_tick();
        wait_readings_drained();
        // counter already above the threshold, it keeps counting
        write_reg(CFG_CHANGE_EVERY, 32'd2);
        for (int i = 0; i < 20; i++)
            send_random_tick();
        wait_readings_drained();
        // threshold a few ticks ahead so the mode flips again
        write_reg(CFG_CHANGE_EVERY, {16'b0, mode_ticks + 16'd3});
        for (int i = 0; i < 20; i++)
            send_random_tick();
    endtask

    // random phases, one sender pause, quiet final phase
    task automatic test_random_traffic;
        for (int phase = 0; phase < 7; phase++)
        begin
            randomize_registers();
            if (phase == 6)
                idling_on = 1'b0;
            for (int i = 0; i < 200; i++)
            begin
                // let the pipeline empty before the tick goes in
                if (phase == 2 && i == 100)
                    wait_readings_drained();
                send_random_tick();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        power_pulses = '0;
        mixed_pulses = '0;
        out_stall    = 1'b0;
        stall_left   = 0;
        mismatches   = 0;
        idling_on    = 1'b1;
        // shadow state as reset leaves it
        regs.interval_ms   = INTERVAL_RST;
        regs.change_every  = CHANGE_EVERY_RST;
        regs.power_scale   = SCALE_RST;
        regs.current_scale = SCALE_RST;
        regs.voltage_scale = SCALE_RST;
        regs.report_enable = REPORT_ENABLE_RST;
        warmup             = '0;
        in_current_mode    = 1'b0;
        mode_ticks         = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_warmup_and_defaults();
        test_register_extremes();
        test_mode_counter_past();
        test_random_traffic();

        // drain and settle before the verdict
        wait_readings_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && readings_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
